### hw/rtl/vertex_transform_perspective_divide_unit_defines.svh
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define VTPD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("vtpd property violated");
`define VTPD_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("vtpd forbidden condition seen");
`else
`define VTPD_ASSERT(lbl, prop)
`define VTPD_NEVER(lbl, cond)
`endif
`endif

### hw/rtl/vtpd_pkg.sv
// Shared types and constants of the vertex transform and perspective divide unit.
package vtpd_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS = 8;
	localparam int REG_W = 64;
	localparam int MAG_W = 64;
	localparam int QBITS = 33;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] vtpd_matrix_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] num_mag;
		logic [MAG_W-1:0]      den_mag;
		logic [2:0]            neg;
		logic                  w_zero;
		logic                  last;
	} vtpd_item_t;
endpackage

### hw/rtl/vtpd_front.sv
// Front end: accepts points, forms the four column sums and classifies them for the divider.
module vtpd_front #(
	parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vtpd_pkg::vtpd_matrix_t matrix,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   in_x,
	input  logic signed [31:0]   in_y,
	input  logic signed [31:0]   in_z,
	input  logic                 in_last,
	output logic                 push_valid,
	input  logic                 push_full,
	output vtpd_pkg::vtpd_item_t push_item
);
	import vtpd_pkg::*;

	logic en;
	logic signed [31:0] m [4][4];
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [63:0] prod_s2 [4][3];
	logic signed [63:0] trans_s2 [4];
	logic signed [64:0] pair_s3 [4][2];
	logic signed [65:0] sum_s4 [4];
	vtpd_item_t item_s5;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				m[r][c] = matrix[r*2 + c/2][(c%2)*32 +: 32];
			end
		end
	end

	assign en = !(v_s5 && push_full);
	assign in_ready = en;
	assign push_valid = v_s5 && !push_full;
	assign push_item = item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= in_x;
			y_s1 <= in_y;
			z_s1 <= in_z;
			last_s1 <= in_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			for (int c = 0; c < 4; c++) begin
				prod_s2[c][0] <= m[0][c] * x_s1;
				prod_s2[c][1] <= m[1][c] * y_s1;
				prod_s2[c][2] <= m[2][c] * z_s1;
				trans_s2[c] <= 64'(m[3][c]) <<< FRAC_BITS;
				pair_s3[c][0] <= 65'(prod_s2[c][0]) + 65'(prod_s2[c][1]);
				pair_s3[c][1] <= 65'(prod_s2[c][2]) + 65'(trans_s2[c]);
				sum_s4[c] <= 66'(pair_s3[c][0]) + 66'(pair_s3[c][1]);
			end
			for (int c = 0; c < 3; c++) begin
				item_s5.num_mag[c] <= sum_s4[c][65] ? MAG_W'(-sum_s4[c]) : MAG_W'(sum_s4[c]);
				item_s5.neg[c] <= sum_s4[c][65] ^ sum_s4[3][65];
			end
			item_s5.den_mag <= sum_s4[3][65] ? MAG_W'(-sum_s4[3]) : MAG_W'(sum_s4[3]);
			item_s5.w_zero <= (sum_s4[3] == '0);
			item_s5.last <= last_s4;
		end
	end
endmodule

### hw/rtl/vtpd_queue.sv
// Short queue between the front end and the divider.
`include "vertex_transform_perspective_divide_unit_defines.svh"
module vtpd_queue #(
	parameter int DEPTH = vtpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_full,
	input  vtpd_pkg::vtpd_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output vtpd_pkg::vtpd_item_t pop_item
);
	import vtpd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	vtpd_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign push_full = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && !push_full;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`VTPD_NEVER(a_no_push_full, push_valid && push_full)
	`VTPD_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`VTPD_ASSERT(a_count_step, do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
endmodule

### hw/rtl/vtpd_back.sv
// Back end: restoring divider pipeline, saturation and output register.
`include "vertex_transform_perspective_divide_unit_defines.svh"
module vtpd_back #(
	parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  vtpd_pkg::vtpd_item_t pop_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   out_x,
	output logic signed [31:0]   out_y,
	output logic signed [31:0]   out_z,
	output logic                 w_was_zero,
	output logic                 out_last
);
	import vtpd_pkg::*;

	localparam int NW = MAG_W + FRAC_BITS;

	typedef struct packed {
		logic       w_zero;
		logic       last;
		logic [2:0] neg;
		logic [2:0] ovf;
	} vtpd_ctl_t;

	logic en;
	logic vld_s [QBITS+1];
	vtpd_ctl_t ctl_s [QBITS+1];
	logic [MAG_W-1:0] den_s [QBITS+1];
	logic [MAG_W-1:0] rem_s [QBITS+1][3];
	logic [QBITS-1:0] lo_s [QBITS+1][3];
	logic [QBITS-1:0] quo_s [QBITS+1][3];
	logic [NW-1:0] num_wide [3];
	logic [MAG_W:0] trial [QBITS][3];
	logic [MAG_W:0] diff [QBITS][3];
	logic [QBITS-1:0] limit [3];
	logic [QBITS-1:0] qsat [3];
	logic [31:0] res [3];
	logic out_valid_q, w_was_zero_q, out_last_q;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;

	assign en = !out_valid_q || out_ready;
	assign pop_ready = en;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_wide[c] = {pop_item.num_mag[c], {FRAC_BITS{1'b0}}};
			for (int j = 0; j < QBITS; j++) begin
				trial[j][c] = {rem_s[j][c], lo_s[j][c][QBITS-1]};
				diff[j][c] = trial[j][c] - {1'b0, den_s[j]};
			end
			limit[c] = ctl_s[QBITS].neg[c] ? QBITS'(33'h0_8000_0000) : QBITS'(33'h0_7FFF_FFFF);
			qsat[c] = (ctl_s[QBITS].ovf[c] || quo_s[QBITS][c] > limit[c]) ?
				limit[c] : quo_s[QBITS][c];
			res[c] = ctl_s[QBITS].w_zero ? 32'd0 :
				(ctl_s[QBITS].neg[c] ? 32'(-qsat[c][31:0]) : qsat[c][31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QBITS; j++) begin
				vld_s[j] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pop_valid;
			for (int j = 0; j < QBITS; j++) begin
				vld_s[j+1] <= vld_s[j];
			end
			out_valid_q <= vld_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0].w_zero <= pop_item.w_zero;
			ctl_s[0].last <= pop_item.last;
			ctl_s[0].neg <= pop_item.neg;
			den_s[0] <= pop_item.den_mag;
			for (int c = 0; c < 3; c++) begin
				ctl_s[0].ovf[c] <= (MAG_W'(num_wide[c][NW-1:QBITS]) >= pop_item.den_mag);
				rem_s[0][c] <= MAG_W'(num_wide[c][NW-1:QBITS]);
				lo_s[0][c] <= num_wide[c][QBITS-1:0];
				quo_s[0][c] <= '0;
			end
			for (int j = 0; j < QBITS; j++) begin
				ctl_s[j+1].w_zero <= ctl_s[j].w_zero;
				ctl_s[j+1].last <= ctl_s[j].last;
				ctl_s[j+1].neg <= ctl_s[j].neg;
				ctl_s[j+1].ovf <= ctl_s[j].ovf;
				den_s[j+1] <= den_s[j];
				for (int c = 0; c < 3; c++) begin
					lo_s[j+1][c] <= lo_s[j][c] << 1;
					if (trial[j][c] >= {1'b0, den_s[j]}) begin
						rem_s[j+1][c] <= diff[j][c][MAG_W-1:0];
						quo_s[j+1][c] <= {quo_s[j][c][QBITS-2:0], 1'b1};
					end else begin
						rem_s[j+1][c] <= trial[j][c][MAG_W-1:0];
						quo_s[j+1][c] <= {quo_s[j][c][QBITS-2:0], 1'b0};
					end
				end
			end
			out_x_q <= res[0];
			out_y_q <= res[1];
			out_z_q <= res[2];
			w_was_zero_q <= ctl_s[QBITS].w_zero;
			out_last_q <= ctl_s[QBITS].last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign w_was_zero = w_was_zero_q;
	assign out_last = out_last_q;

	`VTPD_ASSERT(a_zero_w_clears, out_valid_q && w_was_zero_q |-> {out_x_q, out_y_q, out_z_q} == '0)
	`VTPD_ASSERT(a_stall_holds, out_valid_q && !out_ready |=> out_valid_q && $stable(out_x_q))
	`VTPD_NEVER(a_no_pop_on_stall, pop_ready && out_valid_q && !out_ready)
endmodule

### hw/rtl/vertex_transform_perspective_divide_unit.sv
// Top level of the vertex transform and perspective divide unit.
// The unit takes one point per cycle and returns one projected point per cycle when the output
// is not stalled. A point passes through five front-end stages for the matrix product, the
// queue, one setup stage, 33 restoring divider steps (one quotient bit each, three lanes in
// parallel) and the output register. The matrix is written through the APB port at byte address
// 8*i and must only be changed while the unit is idle.
module vertex_transform_perspective_divide_unit #(
	parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = vtpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               w_was_zero,
	output logic               out_last
);
	import vtpd_pkg::*;

	localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
	localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + 32));

	vtpd_matrix_t regs_q;
	logic push_valid, push_full, pop_valid, pop_ready;
	vtpd_item_t push_item, pop_item;

	assign pready = 1'b1;
	assign prdata = regs_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= {ONE_HI, REG_W'(0), ONE_LO, REG_W'(0),
				REG_W'(0), ONE_HI, REG_W'(0), ONE_LO};
		end else if (psel && penable && pwrite) begin
			regs_q[paddr[5:3]] <= pwdata;
		end
	end

	vtpd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .matrix(regs_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_x(in_x), .in_y(in_y), .in_z(in_z), .in_last(in_last),
		.push_valid(push_valid), .push_full(push_full), .push_item(push_item)
	);

	vtpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_full(push_full), .push_item(push_item),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
	);

	vtpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.w_was_zero(w_was_zero), .out_last(out_last)
	);
endmodule

### bench/tb_top.sv
// Self-checking testbench for the vertex transform and perspective divide unit.
`timescale 1ns / 1ps
module tb_top;
	import vtpd_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 60;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        wz;
		logic        last;
	} proj_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic w_was_zero, out_last;

	logic [63:0] matrix_regs [0:7];
	proj_point_t pending_points [$];
	int mismatches = 0;
	bit idle_enable = 1'b1;

	vertex_transform_perspective_divide_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [31:0] mat_coef(int r, int c);
		logic [63:0] reg_val;
		reg_val = matrix_regs[r * 2 + c / 2];
		return (c % 2) ? reg_val[63:32] : reg_val[31:0];
	endfunction

	function automatic logic signed [127:0] column_total(int c, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic signed [127:0] acc;
		acc = 128'(mat_coef(0, c)) * 128'(x) + 128'(mat_coef(1, c)) * 128'(y)
			+ 128'(mat_coef(2, c)) * 128'(z) + (128'(mat_coef(3, c)) <<< FB);
		return acc;
	endfunction

	function automatic logic [31:0] divide_saturate(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] n, d, q;
		logic neg;
		neg = num[127] ^ den[127];
		n = num[127] ? -num : num;
		d = den[127] ? -den : den;
		q = (n << FB) / d;
		if (neg) begin
			if (q > 128'h8000_0000) q = 128'h8000_0000;
			return 32'(-q);
		end
		if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic proj_point_t project_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic last);
		proj_point_t p;
		logic signed [127:0] w;
		w = column_total(3, x, y, z);
		p = '0;
		p.last = last;
		if (w == 0) begin
			p.wz = 1'b1;
			return p;
		end
		p.x = divide_saturate(column_total(0, x, y, z), w);
		p.y = divide_saturate(column_total(1, x, y, z), w);
		p.z = divide_saturate(column_total(2, x, y, z), w);
		return p;
	endfunction

	task automatic write_matrix_reg(int addr, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 6'(addr);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		matrix_regs[addr / 8] = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic idle_burst();
		repeat ($urandom_range(1, 5)) @(negedge clk);
	endtask

	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			idle_burst();
		end
		in_valid <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		in_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_points.push_back(project_point(x, y, z, last));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic load_matrix(logic [63:0] vals [0:7]);
		for (int i = 0; i < 8; i++) write_matrix_reg(i * 8, vals[i]);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [63:0] rand_reg();
		logic [31:0] lo, hi;
		lo = rand_coord();
		hi = rand_coord();
		return {hi, lo};
	endfunction

	always @(posedge clk) begin
		proj_point_t exp_p;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected transaction at %0t", $realtime);
			end else begin
				exp_p = pending_points.pop_front();
				if (out_x !== exp_p.x || out_y !== exp_p.y || out_z !== exp_p.z
						|| w_was_zero !== exp_p.wz || out_last !== exp_p.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %h %h %h wz=%b l=%b, got %h %h %h wz=%b l=%b",
							exp_p.x, exp_p.y, exp_p.z, exp_p.wz, exp_p.last,
							out_x, out_y, out_z, w_was_zero, out_last);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (idle_enable && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			idle_burst();
		end
		out_ready <= 1'b1;
	end

	task automatic test_reset_matrix();
		logic [31:0] ext [0:4];
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_0000};
		for (int i = 0; i < 5; i++) send_vertex(ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5], i[0]);
		drain_results();
	endtask

	task automatic test_zero_w_and_saturation();
		logic [63:0] m [0:7];
		m = '{64'h7FFF_FFFF_8000_0000, 64'h0000_0001_7FFF_FFFF, 64'h8000_0000_0001_0000,
			64'h0, 64'h0, 64'h0000_0000_8000_0000, 64'h7FFF_FFFF_8000_0000, 64'h0001_0000_0};
		load_matrix(m);
		send_vertex(32'hFFFF_0000, 32'h0, 32'h0, 1'b0);
		send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_vertex(32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 1'b0);
		drain_results();
		m = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
		load_matrix(m);
		send_vertex(32'h1, 32'h1, 32'h1, 1'b1);
		send_vertex(32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		drain_results();
	endtask

	task automatic test_random_points(int count, bit zero_heavy);
		logic [63:0] m [0:7];
		for (int i = 0; i < 8; i++) m[i] = rand_reg();
		if (zero_heavy) m[7][63:32] = 32'h0;
		load_matrix(m);
		for (int i = 0; i < count; i++) begin
			if (zero_heavy && $urandom_range(0, 3) == 0)
				send_vertex(32'h0, 32'h0, 32'h0, 1'($urandom_range(0, 1)));
			else
				send_vertex(rand_coord(), rand_coord(), rand_coord(),
					1'($urandom_range(0, 1)));
		end
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) matrix_regs[i] = '0;
		matrix_regs[0] = 64'h0000_0000_0001_0000;
		matrix_regs[2] = 64'h0001_0000_0000_0000;
		matrix_regs[5] = 64'h0000_0000_0001_0000;
		matrix_regs[7] = 64'h0001_0000_0000_0000;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_reset_matrix();
		test_zero_w_and_saturation();
		for (int p = 0; p < 10; p++) test_random_points(150, p[0]);
		idle_enable = 1'b0;
		test_random_points(150, 1'b0);
		if (mismatches == 0 && pending_points.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end
endmodule
